// ----- rtl/core/pri_pkg.sv -----
// Package for the pulse rate and interval monitor.
// Holds widths, limits, register indexes, shared structs and the percent table.
// No dependencies.
package pri_pkg;

    // Field and state widths
    localparam int unsigned TIME_W  = 24;
    localparam int unsigned BEATS_W = 10;
    localparam int unsigned SCALE_W = 6;
    localparam int unsigned RATE_W  = 16;
    localparam int unsigned INTV_W  = 6;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Number of intervals in one series (a series ends after one more)
    localparam int unsigned INTERVAL_COUNT = 15;

    localparam logic [TIME_W-1:0]  MAX24     = {TIME_W{1'b1}};
    localparam logic [BEATS_W-1:0] MAX_BEATS = {BEATS_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTV_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH     = 3'd4;

    // Register reset values
    localparam logic [TIME_W-1:0]  RST_RATE_WINDOW = 24'd10000000;
    localparam logic [SCALE_W-1:0] RST_RATE_SCALE  = 6'd6;
    localparam logic [TIME_W-1:0]  RST_INTV_THRESH = 24'd50000;
    localparam logic [RATE_W-1:0]  RST_RATE_LOW    = 16'd60;
    localparam logic [RATE_W-1:0]  RST_RATE_HIGH   = 16'd100;

    typedef struct packed {
        logic [TIME_W-1:0]  rate_window;
        logic [SCALE_W-1:0] rate_scale;
        logic [TIME_W-1:0]  intv_thresh;
        logic [RATE_W-1:0]  rate_low;
        logic [RATE_W-1:0]  rate_high;
    } t_cfg;

    typedef struct packed {
        logic               finished;
        logic [BEATS_W-1:0] beats;
    } t_rate_st;

    typedef struct packed {
        logic              finished;
        logic [INTV_W-1:0] long_cnt;
        logic [TIME_W-1:0] latest;
    } t_intv_st;

    typedef struct packed {
        logic [RATE_W-1:0] bpm;
        logic              rate_ready;
        logic              rate_alarm;
        logic [PCT_W-1:0]  pct;
        logic              intv_ready;
        logic [TIME_W-1:0] last_intv;
    } t_result;

    // Long-interval count to saturated percent
    localparam int unsigned PCT_DEPTH = 2 ** INTV_W;
    typedef logic [PCT_W-1:0] t_pct_table [PCT_DEPTH];

    function automatic t_pct_table build_pct_table();
        t_pct_table  tbl;
        int unsigned p;
        for (int unsigned i = 0; i < PCT_DEPTH; i++) begin
            p = (i * 100) / INTERVAL_COUNT;
            if (p > 100) begin
                p = 100;
            end
            tbl[i] = PCT_W'(p);
        end
        return tbl;
    endfunction

    localparam t_pct_table PCT_TABLE = build_pct_table();

endpackage

// ----- rtl/core/pri_rate.sv -----
// Beat counting window of the pulse rate monitor.
// Depends on pri_pkg.
module pri_rate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_restart,
    input  logic                        i_edge,
    input  logic [pri_pkg::TIME_W-1:0]  i_window,
    output pri_pkg::t_rate_st           o_st
);
    import pri_pkg::*;

    logic [TIME_W-1:0]  r_elapsed, n_elapsed;
    logic [BEATS_W-1:0] r_beats, n_beats;
    logic               r_fin, n_fin;

    // Next window state for one tick
    always_comb begin
        n_elapsed = r_elapsed;
        n_beats   = r_beats;
        n_fin     = r_fin;
        if (i_restart) begin
            n_elapsed = '0;
            n_beats   = '0;
            n_fin     = 1'b0;
        end else if (!r_fin) begin
            if (i_edge && (r_beats != MAX_BEATS)) begin
                n_beats = r_beats + 1'b1;
            end
            if (r_elapsed != MAX24) begin
                n_elapsed = r_elapsed + 1'b1;
            end
            n_fin = (n_elapsed >= i_window);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_beats   <= '0;
            r_fin     <= 1'b0;
        end else if (i_load) begin
            r_elapsed <= n_elapsed;
            r_beats   <= n_beats;
            r_fin     <= n_fin;
        end
    end

    assign o_st.finished = r_fin;
    assign o_st.beats    = r_beats;

endmodule

// ----- rtl/core/pri_intv.sv -----
// Capture interval timing and long-interval counting.
// Depends on pri_pkg.
module pri_intv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_restart,
    input  logic                        i_edge,
    input  logic [pri_pkg::TIME_W-1:0]  i_thresh,
    output pri_pkg::t_intv_st           o_st
);
    import pri_pkg::*;

    logic [TIME_W-1:0] r_since, n_since;
    logic [TIME_W-1:0] r_latest, n_latest;
    logic              r_seen, n_seen;
    logic [INTV_W-1:0] r_nseen, n_nseen;
    logic [INTV_W-1:0] r_long, n_long;
    logic              r_fin, n_fin;
    logic [TIME_W-1:0] since_inc;

    assign since_inc = (r_since != MAX24) ? r_since + 1'b1 : r_since;

    // Next interval state for one tick
    always_comb begin
        n_since  = r_since;
        n_latest = r_latest;
        n_seen   = r_seen;
        n_nseen  = r_nseen;
        n_long   = r_long;
        n_fin    = r_fin;
        if (i_restart) begin
            n_since  = '0;
            n_latest = '0;
            n_seen   = 1'b0;
            n_nseen  = '0;
            n_long   = '0;
            n_fin    = 1'b0;
        end else if (!r_fin) begin
            n_since = since_inc;
            if (i_edge) begin
                n_since = '0;
                if (!r_seen) begin
                    // first edge only starts timing
                    n_seen = 1'b1;
                end else begin
                    n_latest = since_inc;
                    n_nseen  = r_nseen + 1'b1;
                    if (since_inc > i_thresh) begin
                        n_long = r_long + 1'b1;
                    end
                    n_fin = (n_nseen > INTV_W'(INTERVAL_COUNT));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since  <= '0;
            r_latest <= '0;
            r_seen   <= 1'b0;
            r_nseen  <= '0;
            r_long   <= '0;
            r_fin    <= 1'b0;
        end else if (i_load) begin
            r_since  <= n_since;
            r_latest <= n_latest;
            r_seen   <= n_seen;
            r_nseen  <= n_nseen;
            r_long   <= n_long;
            r_fin    <= n_fin;
        end
    end

    assign o_st.finished = r_fin;
    assign o_st.long_cnt = r_long;
    assign o_st.latest   = r_latest;

endmodule

// ----- rtl/core/pri_result.sv -----
// Result formation: rate product, alarm compare and percent lookup.
// Depends on pri_pkg.
module pri_result (
    input  pri_pkg::t_cfg      i_cfg,
    input  pri_pkg::t_rate_st  i_rate,
    input  pri_pkg::t_intv_st  i_intv,
    output pri_pkg::t_result   o_res
);
    import pri_pkg::*;

    logic [RATE_W-1:0] product;

    // 10 x 6 bit product always fits in 16 bits
    assign product = RATE_W'(i_rate.beats) * RATE_W'(i_cfg.rate_scale);

    always_comb begin
        o_res.bpm        = i_rate.finished ? product : '0;
        o_res.rate_ready = i_rate.finished;
        o_res.rate_alarm = i_rate.finished &&
                           ((product < i_cfg.rate_low) || (product > i_cfg.rate_high));
        o_res.pct        = i_intv.finished ? PCT_TABLE[i_intv.long_cnt] : '0;
        o_res.intv_ready = i_intv.finished;
        o_res.last_intv  = i_intv.latest;
    end

endmodule

// ----- rtl/core/pulse_rate_interval_monitor.sv -----
// Pulse rate and beat interval monitor, top level.
// An accepted item updates the state registers, whose result then loads the
// output register. Throughput: one item per cycle while output is not stalled.
// Reset (synchronous, active low) clears all measurement state and loads
// register defaults; there is no clearing pass. Depends on pri_pkg and
// pri_rate, pri_intv, pri_result.
module pulse_rate_interval_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [pri_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pri_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic                            i_beat_edge,
    input  logic                            i_capture_edge,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pri_pkg::RATE_W-1:0]      o_beats_per_minute,
    output logic                            o_rate_ready,
    output logic                            o_rate_alarm,
    output logic [pri_pkg::PCT_W-1:0]       o_long_interval_percent,
    output logic                            o_interval_ready,
    output logic [pri_pkg::TIME_W-1:0]      o_last_interval_us
);
    import pri_pkg::*;

    t_cfg      r_cfg;
    t_rate_st  rate_st;
    t_intv_st  intv_st;
    t_result   res;
    t_result   r_out;
    logic      r_s1_valid;
    logic      r_out_valid;
    logic      s1_adv;
    logic      in_acc;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_window <= RST_RATE_WINDOW;
            r_cfg.rate_scale  <= RST_RATE_SCALE;
            r_cfg.intv_thresh <= RST_INTV_THRESH;
            r_cfg.rate_low    <= RST_RATE_LOW;
            r_cfg.rate_high   <= RST_RATE_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RATE_WINDOW: r_cfg.rate_window <= i_cfg_data[TIME_W-1:0];
                CFG_RATE_SCALE:  r_cfg.rate_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_INTV_THRESH: r_cfg.intv_thresh <= i_cfg_data[TIME_W-1:0];
                CFG_RATE_LOW:    r_cfg.rate_low    <= i_cfg_data[RATE_W-1:0];
                CFG_RATE_HIGH:   r_cfg.rate_high   <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: state stage moves on when the output register is free
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    pri_rate u_rate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_acc),
        .i_restart (i_cmd),
        .i_edge    (i_beat_edge),
        .i_window  (r_cfg.rate_window),
        .o_st      (rate_st)
    );

    pri_intv u_intv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_acc),
        .i_restart (i_cmd),
        .i_edge    (i_capture_edge),
        .i_thresh  (r_cfg.intv_thresh),
        .o_st      (intv_st)
    );

    pri_result u_result (
        .i_cfg  (r_cfg),
        .i_rate (rate_st),
        .i_intv (intv_st),
        .o_res  (res)
    );

    // Output register, loaded from the state stage
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_beats_per_minute      = r_out.bpm;
    assign o_rate_ready            = r_out.rate_ready;
    assign o_rate_alarm            = r_out.rate_alarm;
    assign o_long_interval_percent = r_out.pct;
    assign o_interval_ready        = r_out.intv_ready;
    assign o_last_interval_us      = r_out.last_intv;

endmodule
